// ----- hw/rtl/hcbd_pkg.sv -----
// Shared types, constants and byte-class helpers for the chunked body decoder.
// No dependencies; used by hcbd_parser and the top level.
`default_nettype none

package hcbd_pkg;

  // Longest size line in bytes, CR LF included
  localparam int unsigned LINE_MAX  = 32;
  // Width of chunk size and remaining-byte count
  localparam int unsigned SIZE_BITS = 32;
  // Width of the line length counter
  localparam int unsigned LEN_BITS  = 6;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Bytes owed after chunk data
  typedef enum logic [1:0] {
    CRLF_NONE = 2'd0,
    CRLF_LF   = 2'd1,
    CRLF_CR   = 2'd2
  } crlf_t;

  // Per-byte status that travels with the echoed byte
  typedef struct packed {
    logic is_payload;
    logic chunk_end;
    logic body_done;
    logic framing_error;
  } hcbd_result_t;

  // Hex digit decode: bit 4 is valid, bits 3:0 the digit value
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hcbd_parser.sv -----
// Decoder state and per-byte next-state logic for the chunked body framing.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,      // consume one byte this cycle
  input  wire logic [7:0]           data_byte,
  output hcbd_pkg::hcbd_result_t    result
);

  logic [hcbd_pkg::SIZE_BITS-1:0] bytes_remaining, bytes_remaining_next;
  hcbd_pkg::crlf_t                crlf_expected, crlf_expected_next;
  logic [hcbd_pkg::LEN_BITS-1:0]  line_length, line_length_next;
  logic [hcbd_pkg::SIZE_BITS-1:0] size_acc, size_acc_next;
  logic                           prev_cr, prev_cr_next;
  logic                           line_invalid, line_invalid_next;
  logic                           done_flag, done_flag_next;
  logic                           error_flag, error_flag_next;
  logic                           payload, last;
  logic [4:0]                     hex;

  assign hex = hcbd_pkg::hex_decode(data_byte);

  // Next state for one byte
  always_comb begin
    bytes_remaining_next = bytes_remaining;
    crlf_expected_next   = crlf_expected;
    line_length_next     = line_length;
    size_acc_next        = size_acc;
    prev_cr_next         = prev_cr;
    line_invalid_next    = line_invalid;
    done_flag_next       = done_flag;
    error_flag_next      = error_flag;
    payload              = 1'b0;
    last                 = 1'b0;

    if (step && !done_flag && !error_flag) begin
      if (bytes_remaining != '0) begin
        // Pass payload through and count down
        payload              = 1'b1;
        bytes_remaining_next = bytes_remaining - 1'b1;
        last                 = (bytes_remaining == hcbd_pkg::SIZE_BITS'(1));
      end else if (crlf_expected == hcbd_pkg::CRLF_CR) begin
        if (data_byte != hcbd_pkg::CHAR_CR) error_flag_next = 1'b1;
        else crlf_expected_next = hcbd_pkg::CRLF_LF;
      end else if (crlf_expected == hcbd_pkg::CRLF_LF) begin
        if (data_byte != hcbd_pkg::CHAR_LF) error_flag_next = 1'b1;
        else crlf_expected_next = hcbd_pkg::CRLF_NONE;
      end else if (line_length >= hcbd_pkg::LEN_BITS'(hcbd_pkg::LINE_MAX)) begin
        // Size line too long
        error_flag_next = 1'b1;
      end else begin
        line_length_next = line_length + 1'b1;
        if (prev_cr && data_byte == hcbd_pkg::CHAR_LF) begin
          // Line end: need at least one digit before CR LF
          if (line_invalid || line_length < hcbd_pkg::LEN_BITS'(2)) begin
            error_flag_next = 1'b1;
          end else begin
            bytes_remaining_next = size_acc;
            line_length_next     = '0;
            size_acc_next        = '0;
            prev_cr_next         = 1'b0;
            line_invalid_next    = 1'b0;
            crlf_expected_next   = hcbd_pkg::CRLF_CR;
            if (size_acc == '0) done_flag_next = 1'b1;
          end
        end else begin
          line_invalid_next = line_invalid | prev_cr;
          if (data_byte == hcbd_pkg::CHAR_CR) begin
            prev_cr_next = 1'b1;
          end else begin
            prev_cr_next = 1'b0;
            if (!hex[4]) begin
              line_invalid_next = 1'b1;
            end else if (!(line_invalid | prev_cr)) begin
              // Shift in a digit unless the value would overflow
              if (size_acc[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                line_invalid_next = 1'b1;
              end else begin
                size_acc_next = {size_acc[hcbd_pkg::SIZE_BITS-5:0], hex[3:0]};
              end
            end
          end
        end
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      crlf_expected   <= hcbd_pkg::CRLF_NONE;
      line_length     <= '0;
      size_acc        <= '0;
      prev_cr         <= 1'b0;
      line_invalid    <= 1'b0;
      done_flag       <= 1'b0;
      error_flag      <= 1'b0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      crlf_expected   <= crlf_expected_next;
      line_length     <= line_length_next;
      size_acc        <= size_acc_next;
      prev_cr         <= prev_cr_next;
      line_invalid    <= line_invalid_next;
      done_flag       <= done_flag_next;
      error_flag      <= error_flag_next;
    end
  end

  assign result.is_payload    = payload;
  assign result.chunk_end     = last;
  assign result.body_done     = done_flag_next;
  assign result.framing_error = error_flag_next;

endmodule

`default_nettype wire

// ----- hw/rtl/http_chunked_body_decoder_unit.sv -----
// Bytes pass the input register, then hcbd_parser and the result register; a byte leaves
// the input register only when the result register is empty or its transfer is taken.
// Throughput: one byte per cycle unless m_axis_tready stalls; state updates once per byte.
// A stalled result register holds its transfer while a new byte waits in the input register.
// Reset (rst, synchronous, active high) clears both stage valids and all decoder state.
// Top level: input and result registers around hcbd_parser; depends on hcbd_pkg.
`default_nettype none

module http_chunked_body_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] body_done,
                                           // [9] framing_error, [15:10] zero
  output      logic        m_axis_tuser,   // [0] is_payload
  output      logic        m_axis_tlast    // chunk_end
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   out_valid;
  logic [7:0]             out_byte;
  hcbd_pkg::hcbd_result_t out_res;
  hcbd_pkg::hcbd_result_t res;
  logic                   advance;

  // Move the held byte through the decoder when the result register frees up
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  hcbd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .result    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_byte <= in_byte;
      out_res  <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_res.framing_error, out_res.body_done, out_byte};
  assign m_axis_tuser  = out_res.is_payload;
  assign m_axis_tlast  = out_res.chunk_end;

endmodule

`default_nettype wire

// ----- hw/rtl/hcbd_checker.sv -----
// Port-level checks for http_chunked_body_decoder_unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module hcbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic err_seen;

  // Track an error reported on any earlier result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[9]) begin
      err_seen <= 1'b1;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Chunk end only on a payload byte
  a_last_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("chunk end on non-payload byte");

  // No payload once the body is done or broken
  a_no_payload_after_stop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[8] || m_axis_tdata[9]) |-> !m_axis_tuser)
    else $error("payload reported after done or error");

  // Error stays set
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && err_seen |-> m_axis_tdata[9])
    else $error("framing error cleared");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
